### rtl/noes_pkg.sv
// Shared types and constants for the note-off event scheduler.
`timescale 1ns / 1ps
package noes_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int PW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] FUNC_ADD     = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_DRAIN   = 2'd2;

  localparam logic STATUS_POP  = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] time_ms;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPACT,
    S_INSERT,
    S_POP
  } state_t;

endpackage

### rtl/note_off_event_scheduler_core.sv
// Top level: time-ordered queue of pending note-off events in a circular buffer.
//
// Command channel: an item transfers on a rising edge with start high and busy low.
// in_func selects add, release due events up to in_time_req, or drain all
// (the unused code is ignored and leaves busy low).
// Result channel: out_valid strobes one result per cycle; the receiver cannot
// stall, so every strobe is a transfer. out_last marks the final result of an item.
// Add: one pass over the queued entries drops any with the same channel and note,
// then a backward walk shifts later entries up by one through the single read /
// single write port of the entry memory. The walk is skipped when the queue is
// empty after the pass, where the entry is written directly, or still full.
// A full queue gives one status-full result in the same cycle that busy falls.
// Release / drain: one entry pops per cycle off the head pointer, at most 16 per
// item; each result passes a pending register and then the output register, and
// the last one shows in the same cycle that busy falls.
// Reset empties the queue; memory contents are not cleared.
`timescale 1ns / 1ps
module note_off_event_scheduler_core #(
  parameter int QUEUE_DEPTH = noes_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_channel,
  input  logic [6:0]  in_note,
  input  logic [6:0]  in_velocity,
  input  logic [31:0] in_time_req,
  output logic        out_valid,
  output logic        out_status,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_note,
  output logic [6:0]  out_velocity,
  output logic [31:0] out_time,
  output logic        out_last
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int PW = noes_pkg::PW;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] MAX_C = PW'(noes_pkg::MAX_RESULTS);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] ofs);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(ofs);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  noes_pkg::entry_t mem [QUEUE_DEPTH];

  noes_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [PW-1:0] npop_r, npop_nxt;
  logic          drain_r, drain_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  noes_pkg::entry_t ev_r, ev_nxt;
  noes_pkg::entry_t pend_r, pend_nxt;
  noes_pkg::entry_t rd_data_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  noes_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr;
  logic             due;

  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;
  noes_pkg::entry_t out_data_r, out_data_nxt;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    npop_nxt       = npop_r;
    drain_nxt      = drain_r;
    pend_vld_nxt   = pend_vld_r;
    ev_nxt         = ev_r;
    pend_nxt       = pend_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    wr_data        = rd_data_r;
    rd_addr        = head_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = noes_pkg::STATUS_POP;
    out_last_nxt   = 1'b0;
    out_data_nxt   = pend_r;
    due = (cnt_r != '0) && (npop_r != MAX_C) &&
          (drain_r || (rd_data_r.time_ms <= ev_r.time_ms));

    case (state_r)
      noes_pkg::S_IDLE: begin
        if (start) begin
          ev_nxt = '{channel: in_channel, note: in_note, velocity: in_velocity,
                     time_ms: in_time_req};
          idx_nxt      = '0;
          keep_nxt     = '0;
          npop_nxt     = '0;
          pend_vld_nxt = 1'b0;
          drain_nxt    = (in_func == noes_pkg::FUNC_DRAIN);
          case (in_func)
            noes_pkg::FUNC_ADD:     state_nxt = noes_pkg::S_COMPACT;
            noes_pkg::FUNC_RELEASE: state_nxt = noes_pkg::S_POP;
            noes_pkg::FUNC_DRAIN:   state_nxt = noes_pkg::S_POP;
            default:                state_nxt = noes_pkg::S_IDLE;
          endcase
        end
      end
      noes_pkg::S_COMPACT: begin
        if (idx_r != cnt_r) begin
          if (!(rd_data_r.channel == ev_r.channel && rd_data_r.note == ev_r.note)) begin
            wr_en    = 1'b1;
            wr_addr  = wrap_add(head_r, keep_r);
            keep_nxt = keep_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
          rd_addr = wrap_add(head_r, idx_r + 1'b1);
        end else begin
          cnt_nxt = keep_r;
          if (keep_r == DEPTH_C) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = noes_pkg::STATUS_FULL;
            out_last_nxt   = 1'b1;
            out_data_nxt   = ev_r;
            state_nxt      = noes_pkg::S_IDLE;
          end else if (keep_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = head_r;
            wr_data   = ev_r;
            cnt_nxt   = CW'(1);
            state_nxt = noes_pkg::S_IDLE;
          end else begin
            rd_addr   = wrap_add(head_r, keep_r - 1'b1);
            idx_nxt   = keep_r;
            state_nxt = noes_pkg::S_INSERT;
          end
        end
      end
      noes_pkg::S_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = wrap_add(head_r, idx_r);
        if (idx_r != '0 && rd_data_r.time_ms >= ev_r.time_ms) begin
          idx_nxt = idx_r - 1'b1;
          rd_addr = wrap_add(head_r, (idx_r >= CW'(2)) ? idx_r - CW'(2) : '0);
        end else begin
          wr_data   = ev_r;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = noes_pkg::S_IDLE;
        end
      end
      noes_pkg::S_POP: begin
        if (pend_vld_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = !due;
        end
        if (due) begin
          pend_nxt     = rd_data_r;
          pend_vld_nxt = 1'b1;
          head_nxt     = wrap_add(head_r, CW'(1));
          rd_addr      = wrap_add(head_r, CW'(1));
          cnt_nxt      = cnt_r - 1'b1;
          npop_nxt     = npop_r + 1'b1;
        end else begin
          pend_vld_nxt = 1'b0;
          state_nxt    = noes_pkg::S_IDLE;
        end
      end
      default: state_nxt = noes_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= noes_pkg::S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    keep_r       <= keep_nxt;
    npop_r       <= npop_nxt;
    drain_r      <= drain_nxt;
    ev_r         <= ev_nxt;
    pend_r       <= pend_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign busy         = (state_r != noes_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;
  assign out_channel  = out_data_r.channel;
  assign out_note     = out_data_r.note;
  assign out_velocity = out_data_r.velocity;
  assign out_time     = out_data_r.time_ms;

endmodule

### rtl/noes_checker.sv
// Port-level checker for the note-off event scheduler, bound to the top level.
`timescale 1ns / 1ps
module noes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_func,
  input logic [3:0]  in_channel,
  input logic [6:0]  in_note,
  input logic [6:0]  in_velocity,
  input logic [31:0] in_time_req,
  input logic        out_valid,
  input logic        out_status,
  input logic [3:0]  out_channel,
  input logic [6:0]  out_note,
  input logic [6:0]  out_velocity,
  input logic [31:0] out_time,
  input logic        out_last
);

  a_result_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result transfer without a command in progress");

  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == noes_pkg::STATUS_FULL |-> out_last)
    else $error("full status not marked last");

  a_cmd_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_func == noes_pkg::FUNC_ADD || in_func == noes_pkg::FUNC_RELEASE ||
                       in_func == noes_pkg::FUNC_DRAIN) |=> busy)
    else $error("accepted command did not raise busy");

  a_pops_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == noes_pkg::STATUS_POP && !out_last
      |=> out_valid && out_time >= $past(out_time))
    else $error("popped events not back to back in time order");

endmodule

bind note_off_event_scheduler_core noes_checker u_noes_checker (.*);

### bench/note_off_event_scheduler_checker.sv
// Scoreboard for the note-off event scheduler: tracks the queue and checks every result.
`timescale 1ns / 1ps
module note_off_event_scheduler_checker #(
  parameter int DEPTH = noes_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_channel,
  input  logic [6:0]  in_note,
  input  logic [6:0]  in_velocity,
  input  logic [31:0] in_time_req,
  input  logic        out_valid,
  input  logic        out_status,
  input  logic [3:0]  out_channel,
  input  logic [6:0]  out_note,
  input  logic [6:0]  out_velocity,
  input  logic [31:0] out_time,
  input  logic        out_last,
  output int          mismatches,
  output int          outstanding,
  output int          pops_seen,
  output int          drops_seen
);

  typedef struct packed {
    logic             status;
    noes_pkg::entry_t ev;
    logic             last;
  } note_result_t;

  noes_pkg::entry_t queued_notes[$];
  note_result_t     due_results[$];

  task automatic schedule_command(input logic [1:0] func, input noes_pkg::entry_t ev);
    noes_pkg::entry_t kept[$];
    note_result_t     r;
    int               pos;
    int               n;
    if (func == noes_pkg::FUNC_ADD) begin
      foreach (queued_notes[i])
        if (queued_notes[i].channel != ev.channel || queued_notes[i].note != ev.note)
          kept.push_back(queued_notes[i]);
      queued_notes = kept;
      if (queued_notes.size() >= DEPTH) begin
        r.status = noes_pkg::STATUS_FULL;
        r.ev     = ev;
        r.last   = 1'b1;
        due_results.push_back(r);
      end else begin
        pos = 0;
        while (pos < queued_notes.size() && queued_notes[pos].time_ms < ev.time_ms)
          pos++;
        queued_notes.insert(pos, ev);
      end
    end else if (func == noes_pkg::FUNC_RELEASE || func == noes_pkg::FUNC_DRAIN) begin
      n = 0;
      while (n < noes_pkg::MAX_RESULTS && queued_notes.size() > 0 &&
             (func == noes_pkg::FUNC_DRAIN || queued_notes[0].time_ms <= ev.time_ms)) begin
        r.status = noes_pkg::STATUS_POP;
        r.ev     = queued_notes.pop_front();
        r.last   = 1'b0;
        due_results.push_back(r);
        n++;
      end
      if (n > 0)
        due_results[due_results.size() - 1].last = 1'b1;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : watch
    note_result_t got;
    note_result_t want;
    if (!rst_n) begin
      queued_notes.delete();
      due_results.delete();
      outstanding = 0;
    end else begin
      if (out_valid) begin
        got = {out_status, out_channel, out_note, out_velocity, out_time, out_last};
        if (got.status == noes_pkg::STATUS_FULL)
          drops_seen++;
        else
          pops_seen++;
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result st=%0d ch=%0d nt=%0d vel=%0d t=%0d last=%0d",
                                  got.status, got.ev.channel, got.ev.note, got.ev.velocity,
                                  got.ev.time_ms, got.last));
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            flag_mismatch({$sformatf("expected st=%0d ch=%0d nt=%0d vel=%0d t=%0d last=%0d,",
                                     want.status, want.ev.channel, want.ev.note,
                                     want.ev.velocity, want.ev.time_ms, want.last),
                           $sformatf(" got st=%0d ch=%0d nt=%0d vel=%0d t=%0d last=%0d",
                                     got.status, got.ev.channel, got.ev.note,
                                     got.ev.velocity, got.ev.time_ms, got.last)});
        end
      end
      if (start && !busy)
        schedule_command(in_func, {in_channel, in_note, in_velocity, in_time_req});
      outstanding = due_results.size();
    end
  end

endmodule

### bench/note_off_event_scheduler_core_test.sv
// Testbench top for the note-off event scheduler: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module note_off_event_scheduler_core_test;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 320;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 2 * noes_pkg::DEFAULT_QUEUE_DEPTH + 8;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [3:0]  in_channel;
  logic [6:0]  in_note;
  logic [6:0]  in_velocity;
  logic [31:0] in_time_req;
  logic        out_valid;
  logic        out_status;
  logic [3:0]  out_channel;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic [31:0] out_time;
  logic        out_last;

  int          mismatches;
  int          outstanding;
  int          pops_seen;
  int          drops_seen;
  int          adds_sent;
  int          releases_sent;
  int          drains_sent;
  int          idle_cycles;
  logic [31:0] now_ms;

  note_off_event_scheduler_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_channel  (in_channel),
    .in_note     (in_note),
    .in_velocity (in_velocity),
    .in_time_req (in_time_req),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_channel (out_channel),
    .out_note    (out_note),
    .out_velocity(out_velocity),
    .out_time    (out_time),
    .out_last    (out_last)
  );

  note_off_event_scheduler_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_channel  (in_channel),
    .in_note     (in_note),
    .in_velocity (in_velocity),
    .in_time_req (in_time_req),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_channel (out_channel),
    .out_note    (out_note),
    .out_velocity(out_velocity),
    .out_time    (out_time),
    .out_last    (out_last),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .pops_seen   (pops_seen),
    .drops_seen  (drops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue(input logic [1:0] func, input logic [3:0] ch, input logic [6:0] nt,
                       input logic [6:0] vel, input logic [31:0] t);
    @(negedge clk);
    start       <= 1'b1;
    in_func     <= func;
    in_channel  <= ch;
    in_note     <= nt;
    in_velocity <= vel;
    in_time_req <= t;
    do @(posedge clk); while (busy);
    if (func == noes_pkg::FUNC_ADD)
      adds_sent++;
    else if (func == noes_pkg::FUNC_RELEASE)
      releases_sent++;
    else if (func == noes_pkg::FUNC_DRAIN)
      drains_sent++;
  endtask

  task automatic pause(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    issue(noes_pkg::FUNC_RELEASE, 4'd0, 7'd0, 7'd0, '1);
    issue(noes_pkg::FUNC_DRAIN, 4'd0, 7'd0, 7'd0, 32'd0);
    issue(noes_pkg::FUNC_ADD, 4'd15, 7'd127, 7'd127, '1);
    issue(noes_pkg::FUNC_ADD, 4'd0, 7'd0, 7'd0, 32'd0);
    // same key again: old entry must go
    issue(noes_pkg::FUNC_ADD, 4'd0, 7'd0, 7'd5, 32'd100);
    // equal time: lands ahead of the existing entry
    issue(noes_pkg::FUNC_ADD, 4'd3, 7'd60, 7'd64, 32'd100);
    issue(FUNC_UNUSED, 4'd15, 7'd127, 7'd127, '1);
    issue(noes_pkg::FUNC_RELEASE, 4'd0, 7'd0, 7'd0, 32'd99);
    issue(noes_pkg::FUNC_RELEASE, 4'd0, 7'd0, 7'd0, 32'd100);
    issue(noes_pkg::FUNC_RELEASE, 4'd0, 7'd0, 7'd0, '1);
    for (int i = 0; i < noes_pkg::DEFAULT_QUEUE_DEPTH; i++)
      issue(noes_pkg::FUNC_ADD, 4'(i), 7'(40 + i), 7'(3 * i), 32'(500 - (i / 2) * 10));
    issue(noes_pkg::FUNC_ADD, 4'd9, 7'd1, 7'd33, 32'd250);
    // full, but the duplicate frees a slot
    issue(noes_pkg::FUNC_ADD, 4'd2, 7'd42, 7'd11, 32'd0);
    issue(noes_pkg::FUNC_DRAIN, 4'd0, 7'd0, 7'd0, 32'd0);
  endtask

  task automatic random_command(output bit counted);
    int          pick;
    logic [1:0]  f;
    logic [3:0]  ch;
    logic [6:0]  nt;
    logic [6:0]  vel;
    logic [31:0] t;
    pick = $urandom_range(0, 99);
    ch   = 4'($urandom_range(0, 3));
    nt   = 7'(60 + $urandom_range(0, 7));
    vel  = 7'($urandom);
    t    = now_ms + $urandom_range(0, 60);
    if (pick < 58) begin
      f = noes_pkg::FUNC_ADD;
    end else if (pick < 88) begin
      f      = noes_pkg::FUNC_RELEASE;
      now_ms = now_ms + $urandom_range(0, 40);
      t      = now_ms;
    end else if (pick < 92) begin
      f = noes_pkg::FUNC_DRAIN;
    end else if (pick < 97) begin
      f  = 2'($urandom_range(0, 2));
      ch = 4'($urandom);
      nt = 7'($urandom);
      t  = $urandom;
    end else begin
      f = FUNC_UNUSED;
    end
    counted = (f != FUNC_UNUSED);
    issue(f, ch, nt, vel, t);
  endtask

  initial begin
    int sent;
    bit counted;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_func     = noes_pkg::FUNC_ADD;
    in_channel  = '0;
    in_note     = '0;
    in_velocity = '0;
    in_time_req = '0;
    now_ms      = $urandom;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    settle();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_command(counted);
      if (counted)
        sent++;
      if (counted && sent == RANDOM_ITEMS / 2)
        settle();
      if (sent < RANDOM_ITEMS - 40 && (sent / 40) % 2 == 0 && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 18));
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d adds, %0d releases, %0d drains with random gaps and back-to-back runs",
             adds_sent, releases_sent, drains_sent);
    $display("Observed %0d popped events and %0d queue-full drops, %0d mismatches",
             pops_seen, drops_seen, mismatches);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
